@@ sv/bitmap_page_allocator_top_assert.svh @@
// Assertion macros for the page allocator checker
`ifndef BITMAP_PAGE_ALLOCATOR_TOP_ASSERT_SVH
`define BITMAP_PAGE_ALLOCATOR_TOP_ASSERT_SVH

// hold cons in the same cycle as ante
`define BPA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// hold cons in the cycle after ante
`define BPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/bpa_pkg.sv @@
package bpa_pkg;

  localparam int unsigned NUM_PAGES_DEF   = 65536;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;
  localparam int unsigned PAGE_SHIFT      = 12;
  localparam int unsigned WORD_SHIFT      = 5;

  localparam logic [1:0] REQ_ALLOC   = 2'd0;
  localparam logic [1:0] REQ_FREE    = 2'd1;
  localparam logic [1:0] REQ_REGION  = 2'd2;
  localparam logic [1:0] REQ_RESERVE = 2'd3;

  localparam logic [31:0] KIND_AVAIL = 32'd1;

  localparam int unsigned OP_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_NOP   = 3'd0,
    OP_ALLOC = 3'd1,
    OP_FREE  = 3'd2,
    OP_CLR   = 3'd3,
    OP_SET   = 3'd4
  } op_e;

  function automatic logic [5:0] popcnt32(input logic [31:0] v);
    logic [5:0] n;
    n = '0;
    for (int i = 0; i < 32; i++) begin
      n = n + 6'(v[i]);
    end
    return n;
  endfunction

  function automatic logic [4:0] low_zero(input logic [31:0] v);
    logic [4:0] idx;
    idx = '0;
    for (int i = 31; i >= 0; i--) begin
      if (!v[i]) begin
        idx = 5'(i);
      end
    end
    return idx;
  endfunction

endpackage

@@ sv/bpa_front.sv @@
module bpa_front #(
  parameter int unsigned NUM_PAGES = bpa_pkg::NUM_PAGES_DEF,
  localparam int unsigned PW       = $clog2(NUM_PAGES + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        req_type_i,
  input  logic [63:0]       addr_i,
  input  logic [63:0]       region_length_i,
  input  logic [31:0]       region_kind_i,
  input  logic              busy_i,
  output logic              push_o,
  input  logic              full_i,
  output bpa_pkg::op_e      op_o,
  output logic [PW-1:0]     lo_o,
  output logic [PW-1:0]     hi_o
);

  logic               held_q, held_d;
  logic               calc_q, calc_d;
  logic [1:0]         type_q;
  logic [63:0]        addr_q;
  logic [63:0]        len_q;
  logic [31:0]        kind_q;
  bpa_pkg::op_e       cop_q, cop_d;
  logic [53:0]        a_q, a_d;
  logic [51:0]        b_q, b_d;

  logic               accept;
  logic               move;
  logic [11:0]        off;
  logic               has_off;
  logic [12:0]        up;
  logic               len_ok;
  logic [51:0]        lenp;
  logic [52:0]        start;
  logic [51:0]        pg;
  logic [51:0]        last;
  logic [53:0]        endp;

  assign in_stall_o = held_q || busy_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = calc_q && !full_i;
  assign move       = held_q && (!calc_q || push_o);

  always_comb begin
    held_d = held_q;
    calc_d = calc_q;
    if (accept) begin
      held_d = 1'b1;
    end else if (move) begin
      held_d = 1'b0;
    end
    if (move) begin
      calc_d = 1'b1;
    end else if (push_o) begin
      calc_d = 1'b0;
    end
  end

  // classify and work out page bounds
  always_comb begin
    off     = addr_q[11:0];
    has_off = |off;
    up      = has_off ? (13'd4096 - {1'b0, off}) : 13'd0;
    len_ok  = len_q >= 64'(up);
    lenp    = 52'((len_q - 64'(up)) >> bpa_pkg::PAGE_SHIFT);
    start   = {1'b0, addr_q[63:12]} + 53'(has_off);
    pg      = addr_q[63:12];
    last    = (pg >= 52'(NUM_PAGES - 1)) ? 52'(NUM_PAGES - 1) : pg;
    cop_d   = bpa_pkg::OP_NOP;
    a_d     = '0;
    b_d     = '0;
    case (type_q)
      bpa_pkg::REQ_ALLOC: begin
        cop_d = bpa_pkg::OP_ALLOC;
      end
      bpa_pkg::REQ_FREE: begin
        cop_d = (pg < 52'(NUM_PAGES)) ? bpa_pkg::OP_FREE : bpa_pkg::OP_NOP;
        a_d   = 54'(pg);
      end
      bpa_pkg::REQ_REGION: begin
        cop_d = (kind_q == bpa_pkg::KIND_AVAIL && len_ok) ? bpa_pkg::OP_CLR
                                                          : bpa_pkg::OP_NOP;
        a_d   = 54'(start);
        b_d   = lenp;
      end
      default: begin
        cop_d = bpa_pkg::OP_SET;
        a_d   = 54'(last) + 54'd1;
      end
    endcase
  end

  always_comb begin
    endp = a_q + 54'(b_q);
    op_o = cop_q;
    lo_o = '0;
    hi_o = '0;
    case (cop_q)
      bpa_pkg::OP_CLR: begin
        lo_o = (a_q >= 54'(NUM_PAGES)) ? PW'(NUM_PAGES) : PW'(a_q);
        hi_o = (endp >= 54'(NUM_PAGES)) ? PW'(NUM_PAGES) : PW'(endp);
      end
      bpa_pkg::OP_SET: begin
        hi_o = PW'(a_q);
      end
      bpa_pkg::OP_FREE: begin
        lo_o = PW'(a_q);
      end
      default: begin
        lo_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 1'b0;
      calc_q <= 1'b0;
    end else begin
      held_q <= held_d;
      calc_q <= calc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      type_q <= req_type_i;
      addr_q <= addr_i;
      len_q  <= region_length_i;
      kind_q <= region_kind_i;
    end
    if (move) begin
      cop_q <= cop_d;
      a_q   <= a_d;
      b_q   <= b_d;
    end
  end

endmodule

@@ sv/bpa_fifo.sv @@
module bpa_fifo #(
  parameter int unsigned WIDTH = bpa_pkg::OP_W,
  parameter int unsigned DEPTH = bpa_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wp_q, wp_d;
  logic [AW-1:0]    rp_q, rp_d;
  logic [CNTW-1:0]  cnt_q, cnt_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = cnt_q == CNTW'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wp_d = (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
    end
    if (do_pop) begin
      rp_d = (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= data_i;
    end
  end

endmodule

@@ sv/bpa_back.sv @@
module bpa_back #(
  parameter int unsigned NUM_PAGES = bpa_pkg::NUM_PAGES_DEF,
  localparam int unsigned PW       = $clog2(NUM_PAGES + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  output logic          pop_o,
  input  logic          empty_i,
  input  bpa_pkg::op_e  op_i,
  input  logic [PW-1:0] lo_i,
  input  logic [PW-1:0] hi_i,
  output logic          busy_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [27:0]   page_addr_o,
  output logic          ok_o,
  output logic [16:0]   free_count_o
);

  localparam int unsigned WORDS = (NUM_PAGES + 31) / 32;
  localparam int unsigned WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned HW    = $clog2(WORDS + 1);
  localparam int unsigned CW    = PW;
  localparam int unsigned PGW   = WW + bpa_pkg::WORD_SHIFT;

  typedef enum logic [4:0] {
    ST_INIT = 5'b00001,
    ST_IDLE = 5'b00010,
    ST_RD   = 5'b00100,
    ST_MOD  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_e;

  logic [31:0]    mem_q [WORDS];
  logic [31:0]    rd_q;

  state_e         state_q, state_d;
  bpa_pkg::op_e   op_q, op_d;
  logic [WW-1:0]  w_q, w_d;
  logic [PW-1:0]  lo_q, lo_d;
  logic [PW-1:0]  last_q, last_d;
  logic [HW-1:0]  hint_q, hint_d;
  logic [CW-1:0]  free_q, free_d;
  logic [5:0]     delta_q, delta_d;
  logic           dsub_q, dsub_d;
  logic           dapply_q, dapply_d;
  logic           ok_q, ok_d;
  logic [PGW-1:0] page_q, page_d;
  logic           out_valid_q, out_valid_d;
  logic [27:0]    out_page_q, out_page_d;
  logic           out_ok_q, out_ok_d;
  logic [16:0]    out_free_q, out_free_d;

  logic           we;
  logic [31:0]    wdata;
  logic           out_take;
  logic           out_room;
  logic [WW-1:0]  lo_w;
  logic [WW-1:0]  last_w;
  logic [31:0]    lmask;
  logic [31:0]    hmask;
  logic [31:0]    rmask;
  logic [31:0]    bitsel;
  logic [4:0]     zidx;
  logic           zany;

  assign busy_o       = state_q == ST_INIT;
  assign out_valid_o  = out_valid_q;
  assign page_addr_o  = out_page_q;
  assign ok_o         = out_ok_q;
  assign free_count_o = out_free_q;

  assign out_take = out_valid_q && !out_stall_i;
  assign out_room = !out_valid_q || !out_stall_i;

  assign lo_w   = WW'(lo_q >> bpa_pkg::WORD_SHIFT);
  assign last_w = WW'(last_q >> bpa_pkg::WORD_SHIFT);
  assign lmask  = (w_q == lo_w) ? (32'hFFFF_FFFF << lo_q[4:0]) : 32'hFFFF_FFFF;
  assign hmask  = (w_q == last_w) ? (32'hFFFF_FFFF >> (5'd31 - last_q[4:0]))
                                  : 32'hFFFF_FFFF;
  assign rmask  = lmask & hmask;
  assign bitsel = 32'd1 << lo_q[4:0];
  assign zidx   = bpa_pkg::low_zero(rd_q);
  assign zany   = ~&rd_q;

  // fold in the count change of the previous word
  always_comb begin
    free_d = free_q;
    if (dapply_q) begin
      free_d = dsub_q ? (free_q - CW'(delta_q)) : (free_q + CW'(delta_q));
    end
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    w_d         = w_q;
    lo_d        = lo_q;
    last_d      = last_q;
    hint_d      = hint_q;
    delta_d     = delta_q;
    dsub_d      = dsub_q;
    dapply_d    = 1'b0;
    ok_d        = ok_q;
    page_d      = page_q;
    out_valid_d = out_take ? 1'b0 : out_valid_q;
    out_page_d  = out_page_q;
    out_ok_d    = out_ok_q;
    out_free_d  = out_free_q;
    pop_o       = 1'b0;
    we          = 1'b0;
    wdata       = rd_q;
    case (state_q)
      ST_INIT: begin
        we    = 1'b1;
        wdata = 32'hFFFF_FFFF;
        if (w_q == WW'(WORDS - 1)) begin
          w_d     = '0;
          state_d = ST_IDLE;
        end else begin
          w_d = w_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o  = 1'b1;
          op_d   = op_i;
          lo_d   = lo_i;
          last_d = hi_i - 1'b1;
          ok_d   = 1'b0;
          page_d = '0;
          w_d    = WW'(lo_i >> bpa_pkg::WORD_SHIFT);
          case (op_i)
            bpa_pkg::OP_ALLOC: begin
              if (hint_q == HW'(WORDS)) begin
                state_d = ST_FIN;
              end else begin
                w_d     = WW'(hint_q);
                state_d = ST_RD;
              end
            end
            bpa_pkg::OP_FREE: begin
              state_d = ST_RD;
            end
            bpa_pkg::OP_CLR, bpa_pkg::OP_SET: begin
              if (lo_i < hi_i) begin
                state_d = ST_RD;
                if (op_i == bpa_pkg::OP_CLR &&
                    HW'(lo_i >> bpa_pkg::WORD_SHIFT) < hint_q) begin
                  hint_d = HW'(lo_i >> bpa_pkg::WORD_SHIFT);
                end
              end else begin
                ok_d    = 1'b1;
                state_d = ST_FIN;
              end
            end
            default: begin
              state_d = ST_FIN;
            end
          endcase
        end
      end
      ST_RD: begin
        state_d = ST_MOD;
      end
      ST_MOD: begin
        case (op_q)
          bpa_pkg::OP_ALLOC: begin
            if (zany) begin
              we       = 1'b1;
              wdata    = rd_q | (32'd1 << zidx);
              page_d   = {w_q, zidx};
              delta_d  = 6'd1;
              dsub_d   = 1'b1;
              dapply_d = 1'b1;
              ok_d     = 1'b1;
              hint_d   = HW'(w_q);
              state_d  = ST_FIN;
            end else if (w_q == WW'(WORDS - 1)) begin
              hint_d  = HW'(WORDS);
              state_d = ST_FIN;
            end else begin
              w_d     = w_q + 1'b1;
              state_d = ST_RD;
            end
          end
          bpa_pkg::OP_FREE: begin
            if (|(rd_q & bitsel)) begin
              we       = 1'b1;
              wdata    = rd_q & ~bitsel;
              delta_d  = 6'd1;
              dsub_d   = 1'b0;
              dapply_d = 1'b1;
              ok_d     = 1'b1;
              if (HW'(w_q) < hint_q) begin
                hint_d = HW'(w_q);
              end
            end
            state_d = ST_FIN;
          end
          bpa_pkg::OP_CLR, bpa_pkg::OP_SET: begin
            we       = 1'b1;
            dapply_d = 1'b1;
            if (op_q == bpa_pkg::OP_CLR) begin
              wdata   = rd_q & ~rmask;
              delta_d = bpa_pkg::popcnt32(rd_q & rmask);
              dsub_d  = 1'b0;
            end else begin
              wdata   = rd_q | rmask;
              delta_d = bpa_pkg::popcnt32(~rd_q & rmask);
              dsub_d  = 1'b1;
            end
            if (w_q == last_w) begin
              ok_d    = 1'b1;
              state_d = ST_FIN;
            end else begin
              w_d     = w_q + 1'b1;
              state_d = ST_RD;
            end
          end
          default: begin
            state_d = ST_FIN;
          end
        endcase
      end
      ST_FIN: begin
        if (out_room) begin
          out_valid_d = 1'b1;
          out_page_d  = 28'({page_q, 12'd0});
          out_ok_d    = ok_q;
          out_free_d  = 17'(free_d);
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      op_q        <= bpa_pkg::OP_NOP;
      w_q         <= '0;
      lo_q        <= '0;
      last_q      <= '0;
      hint_q      <= HW'(WORDS);
      free_q      <= '0;
      delta_q     <= '0;
      dsub_q      <= 1'b0;
      dapply_q    <= 1'b0;
      ok_q        <= 1'b0;
      page_q      <= '0;
      out_valid_q <= 1'b0;
      out_page_q  <= '0;
      out_ok_q    <= 1'b0;
      out_free_q  <= '0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      w_q         <= w_d;
      lo_q        <= lo_d;
      last_q      <= last_d;
      hint_q      <= hint_d;
      free_q      <= free_d;
      delta_q     <= delta_d;
      dsub_q      <= dsub_d;
      dapply_q    <= dapply_d;
      ok_q        <= ok_d;
      page_q      <= page_d;
      out_valid_q <= out_valid_d;
      out_page_q  <= out_page_d;
      out_ok_q    <= out_ok_d;
      out_free_q  <= out_free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[w_q] <= wdata;
    end
    if (state_q == ST_RD) begin
      rd_q <= mem_q[w_q];
    end
  end

endmodule

@@ sv/bitmap_page_allocator_top.sv @@
// Path from accept to result valid: classify (request register, then op register), queue,
// a read and a modify state per bitmap word visited, then the post state.
// Allocate visits words up from the lowest that may hold a free page; region and reserve
// visit each 32-page word covered. The front part can take a new request while the back part
// is still busy with earlier ones from the queue. Reset: every page used, free count zero;
// an init pass writes all (NUM_PAGES+31)/32 bitmap words as used, with in_stall_o high throughout.
module bitmap_page_allocator_top #(
  parameter int unsigned NUM_PAGES   = bpa_pkg::NUM_PAGES_DEF,
  parameter int unsigned QUEUE_DEPTH = bpa_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [63:0] addr_i,
  input  logic [63:0] region_length_i,
  input  logic [31:0] region_kind_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [27:0] page_addr_o,
  output logic        ok_o,
  output logic [16:0] free_count_o
);

  localparam int unsigned PW = $clog2(NUM_PAGES + 1);
  localparam int unsigned EW = bpa_pkg::OP_W + 2 * PW;

  logic          push;
  logic          full;
  logic          pop;
  logic          empty;
  logic          busy;
  bpa_pkg::op_e  op_f;
  logic [PW-1:0] lo_f;
  logic [PW-1:0] hi_f;
  bpa_pkg::op_e  op_b;
  logic [PW-1:0] lo_b;
  logic [PW-1:0] hi_b;
  logic [EW-1:0] q_in;
  logic [EW-1:0] q_out;

  assign q_in = {op_f, lo_f, hi_f};
  assign op_b = bpa_pkg::op_e'(q_out[EW-1 -: bpa_pkg::OP_W]);
  assign lo_b = q_out[2*PW-1 -: PW];
  assign hi_b = q_out[PW-1:0];

  bpa_front #(
    .NUM_PAGES(NUM_PAGES)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .addr_i          (addr_i),
    .region_length_i (region_length_i),
    .region_kind_i   (region_kind_i),
    .busy_i          (busy),
    .push_o          (push),
    .full_i          (full),
    .op_o            (op_f),
    .lo_o            (lo_f),
    .hi_o            (hi_f)
  );

  bpa_fifo #(
    .WIDTH(EW),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (q_out)
  );

  bpa_back #(
    .NUM_PAGES(NUM_PAGES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_o        (pop),
    .empty_i      (empty),
    .op_i         (op_b),
    .lo_i         (lo_b),
    .hi_i         (hi_b),
    .busy_o       (busy),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .page_addr_o  (page_addr_o),
    .ok_o         (ok_o),
    .free_count_o (free_count_o)
  );

endmodule

@@ sv/bpa_checker.sv @@
`include "bitmap_page_allocator_top_assert.svh"

module bpa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [27:0] page_addr_o,
  input logic        ok_o,
  input logic [16:0] free_count_o
);

  logic [7:0] pend_q, pend_d;
  logic       in_take;
  logic       out_take;

  assign in_take  = in_valid_i && !in_stall_o;
  assign out_take = out_valid_o && !out_stall_i;

  always_comb begin
    pend_d = pend_q;
    if (in_take && !out_take) begin
      pend_d = pend_q + 1'b1;
    end else if (out_take && !in_take) begin
      pend_d = pend_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  `BPA_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(page_addr_o) && $stable(ok_o) && $stable(free_count_o), "result item changed while stalled")
  `BPA_ASSERT_NOW(a_out_origin, out_valid_o, pend_q != 8'd0, "result item without an accepted item")
  `BPA_ASSERT_NOW(a_addr_ok, out_valid_o && page_addr_o != 28'd0, ok_o, "page address on a failed request")
  `BPA_ASSERT_NOW(a_addr_align, out_valid_o, page_addr_o[11:0] == 12'd0, "page address not page aligned")

endmodule

bind bitmap_page_allocator_top bpa_checker u_bpa_checker (.*);

@@ sim/tb_bitmap_page_allocator_top.sv @@
module tb_bitmap_page_allocator_top;

  localparam int unsigned NPAGES     = bpa_pkg::NUM_PAGES_DEF;
  localparam int unsigned PAGE_BYTES = 1 << bpa_pkg::PAGE_SHIFT;
  localparam int unsigned WDOG_LIMIT = 60000;
  localparam int unsigned HOLD_LEN   = 600;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] addr;
    logic [63:0] len;
    logic [31:0] rkind;
  } page_req_t;

  typedef struct packed {
    logic [27:0] page_addr;
    logic        ok;
    logic [16:0] free_count;
  } page_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  req_type_i = '0;
  logic [63:0] addr_i = '0;
  logic [63:0] region_length_i = '0;
  logic [31:0] region_kind_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [27:0] page_addr_o;
  logic        ok_o;
  logic [16:0] free_count_o;

  page_req_t   queued_reqs[$];
  page_res_t   pending_results[$];
  bit          used_pg[NPAGES];
  int unsigned model_free;
  int unsigned n_items;
  int unsigned sent_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned idle_cyc = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  logic        in_taken = 1'b0;

  bitmap_page_allocator_top #(.NUM_PAGES(NPAGES)) dut (.*);

  always #4 clk_i = ~clk_i;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic page_res_t next_page_result(input page_req_t r);
    page_res_t   res;
    logic [63:0] off;
    logic [63:0] up;
    logic [63:0] first_pg;
    logic [63:0] stop_pg;
    logic [63:0] last_pg;
    logic [63:0] pg;
    bit          found;
    res = '0;
    found = 1'b0;
    case (r.kind)
      bpa_pkg::REQ_ALLOC: begin
        for (int p = 0; p < NPAGES && !found; p++) begin
          if (!used_pg[p]) begin
            used_pg[p] = 1'b1;
            model_free--;
            res.page_addr = 28'(p << bpa_pkg::PAGE_SHIFT);
            res.ok = 1'b1;
            found = 1'b1;
          end
        end
      end
      bpa_pkg::REQ_FREE: begin
        pg = r.addr >> bpa_pkg::PAGE_SHIFT;
        if (pg < 64'(NPAGES) && used_pg[int'(pg)]) begin
          used_pg[int'(pg)] = 1'b0;
          model_free++;
          res.ok = 1'b1;
        end
      end
      bpa_pkg::REQ_REGION: begin
        if (r.rkind == bpa_pkg::KIND_AVAIL) begin
          off = r.addr & 64'(PAGE_BYTES - 1);
          up = (off != 0) ? 64'(PAGE_BYTES) - off : 64'd0;
          if (r.len >= up) begin
            first_pg = (r.addr >> bpa_pkg::PAGE_SHIFT) + ((off != 0) ? 64'd1 : 64'd0);
            stop_pg = first_pg + ((r.len - up) >> bpa_pkg::PAGE_SHIFT);
            if (stop_pg > 64'(NPAGES)) stop_pg = 64'(NPAGES);
            for (pg = first_pg; pg < stop_pg; pg++) begin
              if (used_pg[int'(pg)]) begin
                used_pg[int'(pg)] = 1'b0;
                model_free++;
              end
            end
            res.ok = 1'b1;
          end
        end
      end
      default: begin
        last_pg = r.addr >> bpa_pkg::PAGE_SHIFT;
        if (last_pg >= 64'(NPAGES)) last_pg = 64'(NPAGES - 1);
        for (pg = 0; pg <= last_pg; pg++) begin
          if (!used_pg[int'(pg)]) begin
            used_pg[int'(pg)] = 1'b1;
            model_free--;
          end
        end
        res.ok = 1'b1;
      end
    endcase
    res.free_count = 17'(model_free);
    return res;
  endfunction

  function automatic int unsigned idle_pct(input bit rx);
    int unsigned phase;
    phase = (n_items == 0) ? 0 : (sent_cnt * 3) / n_items;
    if (phase == 0) return rx ? 67 : 34;
    if (phase == 1) return rx ? 34 : 67;
    return 0;
  endfunction

  task automatic add_req(input logic [1:0] k, input logic [63:0] a, input logic [63:0] l,
                         input logic [31:0] rk);
    queued_reqs.push_back('{kind: k, addr: a, len: l, rkind: rk});
  endtask

  // driver: offer the next item, hold it until taken
  always @(negedge clk_i) begin
    page_req_t cur;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      if (queued_reqs.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
        cur = queued_reqs.pop_front();
        in_valid_i <= 1'b1;
        req_type_i <= cur.kind;
        addr_i <= cur.addr;
        region_length_i <= cur.len;
        region_kind_i <= cur.rkind;
        sent_cnt <= sent_cnt + 1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver stall, with one long hold-off late in the run
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_items != 0 && sent_cnt >= (5 * n_items) / 6) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_LEN - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < idle_pct(1'b1));
    end
  end

  // monitor: predict on input handshake, compare on output handshake
  always @(posedge clk_i) begin
    page_res_t want;
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        pending_results.push_back(next_page_result('{kind: req_type_i, addr: addr_i,
                                                     len: region_length_i,
                                                     rkind: region_kind_i}));
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $error("result with no request pending");
          err_cnt++;
        end else begin
          want = pending_results.pop_front();
          if (page_addr_o !== want.page_addr) begin
            $error("page_addr: expected %h, got %h", want.page_addr, page_addr_o);
            err_cnt++;
          end
          if (ok_o !== want.ok) begin
            $error("ok: expected %b, got %b", want.ok, ok_o);
            err_cnt++;
          end
          if (free_count_o !== want.free_count) begin
            $error("free_count: expected %0d, got %0d", want.free_count, free_count_o);
            err_cnt++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cyc <= 0;
    end else if (idle_cyc + 1 >= WDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cyc <= idle_cyc + 1;
    end
  end

  initial begin
    int unsigned roll;
    int unsigned base_pg;
    int unsigned npg;
    int unsigned n_alloc;
    logic [63:0] a;
    foreach (used_pg[i]) used_pg[i] = 1'b1;
    model_free = 0;

    add_req(bpa_pkg::REQ_ALLOC, 64'd0, 64'd0, 32'd0);
    add_req(bpa_pkg::REQ_FREE, 64'h0000_0000_0000_0FFF, 64'd0, 32'd0);
    add_req(bpa_pkg::REQ_FREE, 64'd0, 64'd0, 32'd0);
    add_req(bpa_pkg::REQ_FREE, '1, 64'd0, 32'd0);
    add_req(bpa_pkg::REQ_FREE, 64'(NPAGES) << bpa_pkg::PAGE_SHIFT, 64'd0, 32'd0);
    add_req(bpa_pkg::REQ_FREE, (64'(NPAGES - 1) << bpa_pkg::PAGE_SHIFT) | 64'd123, 64'd0,
            32'd0);
    add_req(bpa_pkg::REQ_REGION, 64'h2000, 64'h4000, 32'd0);
    add_req(bpa_pkg::REQ_REGION, 64'h2000, 64'h4000, '1);
    add_req(bpa_pkg::REQ_REGION, 64'h1001, 64'h0FFE, bpa_pkg::KIND_AVAIL);
    add_req(bpa_pkg::REQ_REGION, 64'h1001, 64'h0FFF, bpa_pkg::KIND_AVAIL);
    add_req(bpa_pkg::REQ_REGION, 64'h1001, 64'h2FFF, bpa_pkg::KIND_AVAIL);
    add_req(bpa_pkg::REQ_REGION, 64'hFFFF_FFFF_FFFF_F001, '1, bpa_pkg::KIND_AVAIL);
    add_req(bpa_pkg::REQ_REGION, 64'd0, '1, bpa_pkg::KIND_AVAIL);
    add_req(bpa_pkg::REQ_REGION, 64'h3000, 64'h2000, bpa_pkg::KIND_AVAIL);
    add_req(bpa_pkg::REQ_ALLOC, 64'd0, 64'd0, 32'd0);
    add_req(bpa_pkg::REQ_ALLOC, 64'd0, 64'd0, 32'd0);
    add_req(bpa_pkg::REQ_RESERVE, 64'h5FFF, 64'd0, 32'd0);
    add_req(bpa_pkg::REQ_RESERVE, '1, '1, '1);
    add_req(bpa_pkg::REQ_ALLOC, 64'd0, 64'd0, 32'd0);
    add_req(bpa_pkg::REQ_REGION, 64'd0, 64'd0, bpa_pkg::KIND_AVAIL);
    add_req(bpa_pkg::REQ_REGION, 64'h3000, 64'h10000, bpa_pkg::KIND_AVAIL);
    add_req(bpa_pkg::REQ_ALLOC, 64'd0, 64'd0, 32'd0);
    add_req(bpa_pkg::REQ_FREE, 64'h3ABC, 64'd0, 32'd0);
    add_req(bpa_pkg::REQ_RESERVE, 64'd0, 64'd0, 32'd0);

    while (queued_reqs.size() < 2000) begin
      roll = $urandom_range(99);
      if (roll < 80) begin
        base_pg = $urandom_range(2047);
        npg = $urandom_range(64, 1);
        a = (64'(base_pg) << bpa_pkg::PAGE_SHIFT) | 64'($urandom_range(PAGE_BYTES - 1));
        add_req(bpa_pkg::REQ_REGION, a,
                (64'($urandom_range(npg)) << bpa_pkg::PAGE_SHIFT)
                  | 64'($urandom_range(PAGE_BYTES - 1)),
                bpa_pkg::KIND_AVAIL);
        n_alloc = $urandom_range(npg + 2);
        for (int i = 0; i < n_alloc; i++) begin
          add_req(bpa_pkg::REQ_ALLOC, rand64(), rand64(), $urandom);
          if ($urandom_range(99) < 30) begin
            a = (64'($urandom_range(base_pg + npg)) << bpa_pkg::PAGE_SHIFT)
              | 64'($urandom_range(PAGE_BYTES - 1));
            add_req(bpa_pkg::REQ_FREE, a, rand64(), $urandom);
          end
        end
        if ($urandom_range(99) < 10) begin
          a = (64'($urandom_range(255)) << bpa_pkg::PAGE_SHIFT)
            | 64'($urandom_range(PAGE_BYTES - 1));
          add_req(bpa_pkg::REQ_RESERVE, a, rand64(), $urandom);
        end
      end else if (roll < 95) begin
        case ($urandom_range(2))
          0: add_req(bpa_pkg::REQ_FREE, rand64(), rand64(), $urandom);
          1: add_req(bpa_pkg::REQ_REGION, rand64(), rand64(), $urandom);
          default: add_req(bpa_pkg::REQ_REGION, rand64(), rand64(), bpa_pkg::KIND_AVAIL);
        endcase
      end else if (roll < 97) begin
        if ($urandom_range(1) == 0) begin
          add_req(bpa_pkg::REQ_REGION, 64'($urandom_range(PAGE_BYTES * 4)),
                  rand64() | 64'h1 << 40, bpa_pkg::KIND_AVAIL);
        end else begin
          add_req(bpa_pkg::REQ_RESERVE, rand64() | 64'h1 << 40, rand64(), $urandom);
        end
      end else begin
        repeat (3) add_req(bpa_pkg::REQ_ALLOC, rand64(), rand64(), $urandom);
      end
    end
    n_items = queued_reqs.size();

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    while (queued_reqs.size() != 0 || in_valid_i || pending_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (50) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ bitmap_page_allocator_top.f @@
+incdir+sv
sv/bpa_pkg.sv
sv/bpa_front.sv
sv/bpa_fifo.sv
sv/bpa_back.sv
sv/bitmap_page_allocator_top.sv
sv/bpa_checker.sv
sim/tb_bitmap_page_allocator_top.sv
